FILE: src/sgb_pkg.sv
// shared types, constants and register codes for the separable blur core
// no dependencies; every file of the block but sgb_ram imports this package

package sgb_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int MAX_RADIUS_DEF = 4;

  localparam int PIX_W      = 8;
  localparam int RGB_W      = 3 * PIX_W;
  localparam int COEF_W     = 17;
  localparam int NCOEF      = 5;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = PIX_W + 1 + COEF_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [10:0]       WIDTH_RST  = 11'd1024;
  localparam logic [12:0]       HEIGHT_RST = 13'd1024;
  localparam logic [COEF_W-1:0] CENTER_RST = 17'h10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_BLUR_RADIUS  = 3'd2,
    CFG_COEF_CENTER  = 3'd3,
    CFG_COEF_DIST1   = 3'd4,
    CFG_COEF_DIST2   = 3'd5,
    CFG_COEF_DIST3   = 3'd6,
    CFG_COEF_DIST4   = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_e;

  typedef struct packed {
    logic       command;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } sgb_in_t;

  typedef struct packed {
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [9:0]  out_column;
    logic [11:0] out_row;
    logic        last_in_run;
    logic        frame_done;
  } sgb_out_t;

endpackage

FILE: src/sgb_ram.sv
// generic single write port ram with one registered read port
// no dependencies

module sgb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/sgb_tap_lane.sv
// one tap lane: adds the mirrored tap pair and scales by the tap weight
// depends on sgb_pkg

module sgb_tap_lane (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [sgb_pkg::PIX_W-1:0]    a_i,
  input  logic [sgb_pkg::PIX_W-1:0]    b_i,
  input  logic [sgb_pkg::COEF_W-1:0]   coef_i,
  output logic [sgb_pkg::PROD_W-1:0]   prod_o
);
  import sgb_pkg::*;

  logic [PIX_W:0]    pair;
  logic [PROD_W-1:0] prod_d, prod_q;

  assign pair   = {1'b0, a_i} + {1'b0, b_i};
  assign prod_d = PROD_W'(pair) * PROD_W'(coef_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

FILE: src/sgb_merge.sv
// merges the lane products of one channel: sum, drop fraction, saturate
// depends on sgb_pkg

module sgb_merge #(
  parameter int NL = 5
) (
  input  logic [sgb_pkg::PROD_W-1:0] prod_i [NL],
  output logic [sgb_pkg::PIX_W-1:0]  pix_o
);
  import sgb_pkg::*;

  localparam int SUM_W = PROD_W + $clog2(NL);

  logic [SUM_W-1:0] sum;

  always_comb begin
    sum = '0;
    for (int i = 0; i < NL; i++) begin
      sum = sum + SUM_W'(prod_i[i]);
    end
  end

  // anything above the integer byte means saturation
  assign pix_o = (|sum[SUM_W-1:FRAC_W+PIX_W]) ? {PIX_W{1'b1}}
                                              : sum[FRAC_W+PIX_W-1:FRAC_W];

endmodule

FILE: src/separable_gaussian_blur_rgb_core.sv
// Separable blur of a raster RGB pixel stream, top level. The core runs a symmetric kernel of
// up to 2*MAX_RADIUS+1 taps along each row, keeps the row results in a line store of
// 2*MAX_RADIUS+1 rows, then runs the same kernel down each column, with mirrored borders.
// Rate: one pixel beat per clock in mid-row while the output is not stalled. The last pixel
// of a row releases up to radius+1 column results; the shared issue stage sends one column per
// clock, and the input stalls until the last of them has issued. Each drain beat yields one
// result while results are pending; after the last pixel of a frame, min(height, radius)*width
// drain beats flush the remaining rows. An issued column passes stages a to e and then the
// output register. The line store has no clearing pass, so the block takes pixels straight out
// of reset. Whenever the output is stalled the whole pipeline holds.
// depends on sgb_pkg, sgb_ram, sgb_tap_lane and sgb_merge

module separable_gaussian_blur_rgb_core #(
  parameter int MAX_WIDTH  = sgb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sgb_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_RADIUS = sgb_pkg::MAX_RADIUS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // pixel / drain beats in
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  sgb_pkg::sgb_in_t               in_data_i,
  // result beats out
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output sgb_pkg::sgb_out_t              out_data_o,
  // register writes
  input  logic                           cfg_we_i,
  input  logic [sgb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sgb_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sgb_pkg::*;

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int R   = MAX_RADIUS;
  localparam int WIN = 2 * R + 1;
  localparam int SW  = $clog2(WIN);
  localparam int NL  = R + 1;
  localparam int DCW = $clog2(R * MAX_WIDTH + 1);

  typedef logic [SW-1:0]   slot_t;
  typedef logic signed [4:0] off_t;

  typedef struct packed {
    logic          emit;
    logic          last;
    logic          done;
    logic [XW-1:0] x;
    logic [YW-1:0] y;
  } tag_t;

  // mirrored neighbor position, returned as an offset from pos
  function automatic off_t mirror_rel(input int pos, input int k, input int lim);
    int p;
    int i;
    p = pos + k;
    if (p < 0) begin
      i = -p - 1;
    end else if (p > lim) begin
      i = 2 * lim + 1 - p;
    end else begin
      i = p;
    end
    if (i < 0) begin
      i = 0;
    end
    if (i > lim) begin
      i = lim;
    end
    return off_t'(i - pos);
  endfunction

  // circular slot arithmetic over the window
  function automatic slot_t slot_add(input slot_t s, input off_t e);
    int t;
    t = int'(s) + int'(e);
    if (t < 0) begin
      t = t + WIN;
    end else if (t >= WIN) begin
      t = t - WIN;
    end
    return slot_t'(t);
  endfunction

  // ---------------------------------------------------------------- registers
  logic [10:0]       iw_q;
  logic [12:0]       ih_q;
  logic [2:0]        rad_q;
  logic [COEF_W-1:0] coef_q [NCOEF];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iw_q  <= WIDTH_RST;
      ih_q  <= HEIGHT_RST;
      rad_q <= '0;
      coef_q[0] <= CENTER_RST;
      for (int i = 1; i < NCOEF; i++) begin
        coef_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_IMAGE_WIDTH:  iw_q      <= cfg_data_i[10:0];
        CFG_IMAGE_HEIGHT: ih_q      <= cfg_data_i[12:0];
        CFG_BLUR_RADIUS:  rad_q     <= cfg_data_i[2:0];
        CFG_COEF_CENTER:  coef_q[0] <= cfg_data_i;
        CFG_COEF_DIST1:   coef_q[1] <= cfg_data_i;
        CFG_COEF_DIST2:   coef_q[2] <= cfg_data_i;
        CFG_COEF_DIST3:   coef_q[3] <= cfg_data_i;
        CFG_COEF_DIST4:   coef_q[4] <= cfg_data_i;
      endcase
    end
  end

  // effective sizes: last column, last row, radius
  logic [XW-1:0]     wm1;
  logic [YW-1:0]     hm1;
  logic [2:0]        r_eff;
  logic [COEF_W-1:0] cm [NL];

  always_comb begin
    if (iw_q == '0) begin
      wm1 = '0;
    end else if (32'(iw_q) > 32'(MAX_WIDTH)) begin
      wm1 = XW'(MAX_WIDTH - 1);
    end else begin
      wm1 = XW'(iw_q - 11'd1);
    end
    if (ih_q == '0) begin
      hm1 = '0;
    end else if (32'(ih_q) > 32'(MAX_HEIGHT)) begin
      hm1 = YW'(MAX_HEIGHT - 1);
    end else begin
      hm1 = YW'(ih_q - 13'd1);
    end
    r_eff = (32'(rad_q) > 32'(R)) ? 3'(R) : rad_q;
    // taps beyond the radius get no weight
    for (int d = 0; d < NL; d++) begin
      cm[d] = (32'(d) <= 32'(r_eff)) ? coef_q[d] : '0;
    end
  end

  // ---------------------------------------------------------------- handshake
  logic out_valid_q;
  logic adv;
  logic in_take;
  logic accept;
  logic issue_last;

  // every stage moves together when the output register can take a beat
  assign adv = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------- stream state
  logic [RGB_W-1:0] rw_q [WIN];
  logic [XW-1:0]    col_q;
  slot_t            col_slot_q;
  logic [YW-1:0]    row_q;
  slot_t            row_slot_q;
  logic [DCW-1:0]   drain_cnt_q;
  logic [XW-1:0]    dr_x_q;
  logic [YW-1:0]    dr_y_q;
  slot_t            dr_slot_q;

  // current column job: a row result (pixel jobs) and maybe a column result per unstalled clock
  logic          job_act_q;
  logic          job_drain_q;
  logic [XW-1:0] job_x_q;
  slot_t         job_xslot_q;
  logic [XW-1:0] job_hi_q;
  logic [YW-1:0] job_y_q;
  slot_t         job_yslot_q;
  slot_t         job_wslot_q;
  logic          job_emit_q;

  assign issue_last = job_drain_q || (job_x_q == job_hi_q);
  assign in_take    = adv && (!job_act_q || issue_last);
  assign in_stall_o = !in_take;
  assign accept     = in_valid_i && in_take;

  // pixel beat decode
  logic [XW-1:0]    pc, p_lo, p_hi, r_x;
  logic [YW-1:0]    prow;
  logic [2:0]       p_dl, nr;
  logic             p_end, p_nonempty, p_emit, p_lastrow;
  logic [XW:0]      w_eff;
  logic [DCW-1:0]   dr_total;
  logic [YW-1:0]    dr_y0;
  slot_t            dr_slot0;
  logic [RGB_W-1:0] pix;

  always_comb begin
    pix        = {in_data_i.red_in, in_data_i.green_in, in_data_i.blue_in};
    r_x        = XW'(r_eff);
    pc         = (col_q > wm1) ? wm1 : col_q;
    prow       = (row_q > hm1) ? hm1 : row_q;
    p_end      = (pc == wm1);
    p_lastrow  = (prow == hm1);
    // first column this pixel completes: max(c - radius, 0)
    p_dl       = (pc < r_x) ? pc[2:0] : r_eff;
    p_lo       = pc - XW'(p_dl);
    p_hi       = p_end ? pc : pc - r_x;
    p_nonempty = p_end || (pc >= r_x);
    p_emit     = (prow >= YW'(r_eff));
    // rows left for the drain beats at the end of a frame
    nr         = (hm1 < YW'(r_eff)) ? 3'(hm1) + 3'd1 : r_eff;
    w_eff      = {1'b0, wm1} + (XW+1)'(1);
    dr_total   = DCW'(nr) * DCW'(w_eff);
    dr_y0      = YW'({1'b0, hm1} + (YW+1)'(1) - (YW+1)'(nr));
    dr_slot0   = slot_add(row_slot_q, off_t'(1) - off_t'(nr));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WIN; i++) begin
        rw_q[i] <= '0;
      end
      col_q       <= '0;
      col_slot_q  <= '0;
      row_q       <= '0;
      row_slot_q  <= '0;
      drain_cnt_q <= '0;
      dr_x_q      <= '0;
      dr_y_q      <= '0;
      dr_slot_q   <= '0;
      job_act_q   <= 1'b0;
      job_drain_q <= 1'b0;
      job_x_q     <= '0;
      job_xslot_q <= '0;
      job_hi_q    <= '0;
      job_y_q     <= '0;
      job_yslot_q <= '0;
      job_wslot_q <= '0;
      job_emit_q  <= 1'b0;
    end else begin
      if (accept && cmd_e'(in_data_i.command) == CMD_PIXEL) begin
        rw_q[col_slot_q] <= pix;
        job_act_q   <= p_nonempty;
        job_drain_q <= 1'b0;
        job_x_q     <= p_lo;
        job_xslot_q <= slot_add(col_slot_q, -off_t'(p_dl));
        job_hi_q    <= p_hi;
        job_y_q     <= prow - YW'(r_eff);
        job_yslot_q <= slot_add(row_slot_q, -off_t'(r_eff));
        job_wslot_q <= row_slot_q;
        job_emit_q  <= p_emit;
        drain_cnt_q <= '0;
        if (p_end) begin
          col_q      <= '0;
          col_slot_q <= '0;
          if (p_lastrow) begin
            // frame end: arm the drain cursor on the first pending row
            row_q       <= '0;
            row_slot_q  <= '0;
            drain_cnt_q <= dr_total;
            dr_x_q      <= '0;
            dr_y_q      <= dr_y0;
            dr_slot_q   <= dr_slot0;
          end else begin
            row_q      <= prow + YW'(1);
            row_slot_q <= slot_add(row_slot_q, off_t'(1));
          end
        end else begin
          col_q      <= pc + XW'(1);
          col_slot_q <= slot_add(col_slot_q, off_t'(1));
        end
      end else if (accept) begin
        // drain beat: one pending result if any
        job_act_q   <= (drain_cnt_q != '0);
        job_drain_q <= 1'b1;
        job_x_q     <= dr_x_q;
        job_hi_q    <= dr_x_q;
        job_y_q     <= dr_y_q;
        job_yslot_q <= dr_slot_q;
        job_emit_q  <= 1'b1;
        if (drain_cnt_q != '0) begin
          drain_cnt_q <= drain_cnt_q - DCW'(1);
          if (dr_x_q == wm1) begin
            dr_x_q    <= '0;
            dr_y_q    <= dr_y_q + YW'(1);
            dr_slot_q <= slot_add(dr_slot_q, off_t'(1));
          end else begin
            dr_x_q <= dr_x_q + XW'(1);
          end
        end
      end else if (adv && job_act_q) begin
        if (issue_last) begin
          job_act_q <= 1'b0;
        end else begin
          job_x_q     <= job_x_q + XW'(1);
          job_xslot_q <= slot_add(job_xslot_q, off_t'(1));
        end
      end
    end
  end

  // ---------------------------------------------------------------- issue
  // horizontal taps come straight out of the row window, vertical taps as slots
  logic [RGB_W-1:0] htap_d [WIN];
  slot_t            vslot_d [WIN];

  always_comb begin
    for (int k = 0; k < WIN; k++) begin
      htap_d[k]  = rw_q[slot_add(job_xslot_q,
                                 mirror_rel(int'(job_x_q), k - R, int'(wm1)))];
      vslot_d[k] = slot_add(job_yslot_q, mirror_rel(int'(job_y_q), k - R, int'(hm1)));
    end
  end

  // stage a: horizontal taps
  logic             a_valid_q, a_wr_q;
  tag_t             a_tag_q;
  slot_t            a_wslot_q;
  slot_t            a_vslot_q [WIN];
  logic [RGB_W-1:0] a_htap_q [WIN];
  // stage b: horizontal products
  logic             b_valid_q, b_wr_q;
  tag_t             b_tag_q;
  slot_t            b_wslot_q;
  slot_t            b_vslot_q [WIN];
  // stage c: line store read data
  logic             c_valid_q, c_wr_q;
  tag_t             c_tag_q;
  slot_t            c_wslot_q;
  slot_t            c_vslot_q [WIN];
  logic [RGB_W-1:0] c_hv_q;
  // stage d: vertical taps
  logic             d_valid_q;
  tag_t             d_tag_q;
  logic [RGB_W-1:0] d_vtap_q [WIN];
  // stage e: vertical products
  logic             e_valid_q;
  tag_t             e_tag_q;
  sgb_out_t         out_q;

  logic [RGB_W-1:0] hv;
  logic [RGB_W-1:0] vtap_d [WIN];
  logic [RGB_W-1:0] ram_q [WIN];
  logic [PIX_W-1:0] vpix [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      d_valid_q   <= 1'b0;
      e_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q   <= job_act_q;
      b_valid_q   <= a_valid_q;
      c_valid_q   <= b_valid_q;
      d_valid_q   <= c_valid_q && c_tag_q.emit;
      e_valid_q   <= d_valid_q;
      out_valid_q <= e_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_wr_q       <= !job_drain_q;
      a_tag_q.emit <= job_emit_q;
      a_tag_q.last <= issue_last;
      a_tag_q.done <= (job_x_q == wm1) && (job_y_q == hm1);
      a_tag_q.x    <= job_x_q;
      a_tag_q.y    <= job_y_q;
      a_wslot_q    <= job_wslot_q;
      a_vslot_q    <= vslot_d;
      a_htap_q     <= htap_d;

      b_wr_q    <= a_wr_q;
      b_tag_q   <= a_tag_q;
      b_wslot_q <= a_wslot_q;
      b_vslot_q <= a_vslot_q;

      c_wr_q    <= b_wr_q;
      c_tag_q   <= b_tag_q;
      c_wslot_q <= b_wslot_q;
      c_vslot_q <= b_vslot_q;
      c_hv_q    <= hv;

      d_tag_q  <= c_tag_q;
      d_vtap_q <= vtap_d;

      e_tag_q <= d_tag_q;

      out_q.red_out     <= vpix[0];
      out_q.green_out   <= vpix[1];
      out_q.blue_out    <= vpix[2];
      out_q.out_column  <= 10'(e_tag_q.x);
      out_q.out_row     <= 12'(e_tag_q.y);
      out_q.last_in_run <= e_tag_q.last;
      out_q.frame_done  <= e_tag_q.done;
    end
  end

  // ---------------------------------------------------------------- lanes
  logic [PROD_W-1:0] hprod [3][NL];
  logic [PROD_W-1:0] vprod [3][NL];
  logic [PIX_W-1:0]  hpix [3];

  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    localparam int HI = RGB_W - 1 - PIX_W * ch;
    for (genvar d = 0; d < NL; d++) begin : g_lane
      logic [PIX_W-1:0] ha, hb, va, vb;
      assign ha = a_htap_q[R + d][HI -: PIX_W];
      assign va = d_vtap_q[R + d][HI -: PIX_W];
      // the center tap has no partner
      assign hb = (d == 0) ? '0 : a_htap_q[R - d][HI -: PIX_W];
      assign vb = (d == 0) ? '0 : d_vtap_q[R - d][HI -: PIX_W];

      sgb_tap_lane u_hlane (
        .clk_i  (clk_i),
        .en_i   (adv),
        .a_i    (ha),
        .b_i    (hb),
        .coef_i (cm[d]),
        .prod_o (hprod[ch][d])
      );

      sgb_tap_lane u_vlane (
        .clk_i  (clk_i),
        .en_i   (adv),
        .a_i    (va),
        .b_i    (vb),
        .coef_i (cm[d]),
        .prod_o (vprod[ch][d])
      );
    end

    sgb_merge #(.NL(NL)) u_hmerge (
      .prod_i (hprod[ch]),
      .pix_o  (hpix[ch])
    );

    sgb_merge #(.NL(NL)) u_vmerge (
      .prod_i (vprod[ch]),
      .pix_o  (vpix[ch])
    );
  end

  assign hv = {hpix[0], hpix[1], hpix[2]};

  // ---------------------------------------------------------------- line store
  // one ram per window row; row results written and columns read in the same stage
  logic [WIN-1:0] ram_we;

  for (genvar j = 0; j < WIN; j++) begin : g_line
    assign ram_we[j] = adv && b_valid_q && b_wr_q && (b_wslot_q == SW'(j));

    sgb_ram #(.WIDTH(RGB_W), .DEPTH(MAX_WIDTH)) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we[j]),
      .waddr_i (b_tag_q.x),
      .wdata_i (hv),
      .re_i    (adv),
      .raddr_i (b_tag_q.x),
      .rdata_o (ram_q[j])
    );
  end

  // the row just written is taken from the forwarded row result
  always_comb begin
    for (int k = 0; k < WIN; k++) begin
      vtap_d[k] = (c_wr_q && (c_vslot_q[k] == c_wslot_q)) ? c_hv_q : ram_q[c_vslot_q[k]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------- checks
  a_job_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_act_q && !job_drain_q) |-> (job_x_q <= job_hi_q))
    else $error("column job ran past its last column");

  a_one_row_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(ram_we))
    else $error("more than one line store row written");

  a_drain_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_e'(in_data_i.command) == CMD_DRAIN && drain_cnt_q != '0)
      |=> (drain_cnt_q == DCW'($past(drain_cnt_q) - DCW'(1))))
    else $error("drain beat did not consume one pending result");

  a_pixel_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_e'(in_data_i.command) == CMD_PIXEL)
      |=> (drain_cnt_q == '0 || (col_q == '0 && row_q == '0)))
    else $error("drain armed away from a frame end");

endmodule

FILE: tb/sv/separable_gaussian_blur_rgb_core_test.sv
// self-checking bench for the separable blur core: drives whole frames of pixel and drain beats
// and compares every result beat against a predictor held in a small scoreboard class
// depends on sgb_pkg and the separable_gaussian_blur_rgb_core top level

module separable_gaussian_blur_rgb_core_test;
  import sgb_pkg::*;

  localparam int WIN  = 2 * MAX_RADIUS_DEF + 1;
  localparam int MAXW = MAX_WIDTH_DEF;

  // predictor of the blur plus the queue of blurred pixels still owed by the core
  class blur_scoreboard;
    logic [23:0]   row_win [WIN];
    logic [23:0]   lines [WIN*MAXW];
    int            col_in, row_in, drain_left;
    logic [10:0]   width_reg;
    logic [12:0]   height_reg;
    logic [2:0]    radius_reg;
    logic [16:0]   coef [NCOEF];
    sgb_out_t      owed_q [$];
    int            errors, results;

    function new();
      width_reg = WIDTH_RST; height_reg = HEIGHT_RST; radius_reg = 0;
      coef[0] = CENTER_RST;
      for (int i = 1; i < NCOEF; i++) coef[i] = 0;
      for (int i = 0; i < WIN; i++) row_win[i] = 0;
      col_in = 0; row_in = 0; drain_left = 0; errors = 0; results = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [16:0] val);
      case (idx)
        CFG_IMAGE_WIDTH:  width_reg = val[10:0];
        CFG_IMAGE_HEIGHT: height_reg = val[12:0];
        CFG_BLUR_RADIUS:  radius_reg = val[2:0];
        default:          coef[int'(idx) - int'(CFG_COEF_CENTER)] = val;
      endcase
    endfunction

    function int eff_w();
      return (width_reg < 1) ? 1 : (width_reg > MAXW) ? MAXW : int'(width_reg);
    endfunction
    function int eff_h();
      return (height_reg < 1) ? 1 : (height_reg > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF
                                                                   : int'(height_reg);
    endfunction
    function int eff_r();
      return (radius_reg > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : int'(radius_reg);
    endfunction

    // reflect about the border, then clamp
    function int reflect(int i, int n);
      if (i < 0) i = -i - 1;
      else if (i >= n) i = 2 * n - i - 1;
      if (i < 0) i = 0;
      if (i > n - 1) i = n - 1;
      return i;
    endfunction

    // weighted sum of the taps px[k+4], k in -r..r, truncated and saturated per channel
    function logic [23:0] weigh(logic [23:0] px [WIN], int r);
      longint      acc [3];
      logic [23:0] res;
      for (int ch = 0; ch < 3; ch++) acc[ch] = 0;
      for (int k = -r; k <= r; k++)
        for (int ch = 0; ch < 3; ch++)
          acc[ch] += longint'(px[k+4][23-8*ch -: 8]) * longint'(coef[k < 0 ? -k : k]);
      for (int ch = 0; ch < 3; ch++) begin
        acc[ch] = acc[ch] >>> 16;
        res[23-8*ch -: 8] = (acc[ch] > 255) ? 8'hff : acc[ch][7:0];
      end
      return res;
    endfunction

    function logic [23:0] row_blur(int x, int w, int r);
      logic [23:0] px [WIN];
      for (int k = -r; k <= r; k++) px[k+4] = row_win[reflect(x + k, w) % WIN];
      return weigh(px, r);
    endfunction

    function logic [23:0] col_blur(int y, int x, int h, int r);
      logic [23:0] px [WIN];
      for (int k = -r; k <= r; k++) px[k+4] = lines[(reflect(y + k, h) % WIN) * MAXW + x % MAXW];
      return weigh(px, r);
    endfunction

    function void owe(logic [23:0] pix, int x, int y, int w, int h);
      sgb_out_t o;
      o.red_out = pix[23:16]; o.green_out = pix[15:8]; o.blue_out = pix[7:0];
      o.out_column = x[9:0]; o.out_row = y[11:0]; o.last_in_run = 1'b0;
      o.frame_done = (x == w - 1 && y == h - 1);
      owed_q.push_back(o);
    endfunction

    function int first_pending_row(int h, int r);
      return (h > r) ? h - r : 0;
    endfunction

    // note one accepted input beat and work out what it causes
    function void note(sgb_in_t d);
      int w, h, r, ys, total, idx, x, y, c, row, lo, hi, n;
      w = eff_w(); h = eff_h(); r = eff_r(); n = 0;
      if (d.command == CMD_DRAIN) begin
        if (drain_left == 0) return;
        ys = first_pending_row(h, r);
        total = (h - ys) * w;
        idx = (total >= drain_left) ? total - drain_left : 0;
        y = ys + idx / w; x = idx % w;
        if (y > h - 1) y = h - 1;
        owe(col_blur(y, x, h, r), x, y, w, h);
        owed_q[owed_q.size()-1].last_in_run = 1'b1;
        drain_left--;
      end else begin
        c = col_in; row = row_in;
        drain_left = 0;
        if (c > w - 1) c = w - 1;
        if (row > h - 1) row = h - 1;
        row_win[c % WIN] = {d.red_in, d.green_in, d.blue_in};
        hi = (c == w - 1) ? c : c - r;
        lo = (c - r < 0) ? 0 : c - r;
        for (x = lo; x <= hi; x++) begin
          lines[(row % WIN) * MAXW + x] = row_blur(x, w, r);
          if (row >= r) begin
            owe(col_blur(row - r, x, h, r), x, row - r, w, h);
            n++;
          end
        end
        if (n > 0) owed_q[owed_q.size()-1].last_in_run = 1'b1;
        if (c >= w - 1) begin
          col_in = 0;
          if (row >= h - 1) begin
            row_in = 0;
            drain_left = (h - first_pending_row(h, r)) * w;
          end else row_in = row + 1;
        end else col_in = c + 1;
      end
    endfunction

    task report(string what, int got, int want);
      errors++;
      $display("mismatch: %s got %0d want %0d (result %0d)", what, got, want, results);
    endtask

    task check(sgb_out_t got);
      sgb_out_t want;
      if (owed_q.size() == 0) begin
        report("result beat with nothing owed", 1, 0);
        return;
      end
      want = owed_q.pop_front();
      results++;
      if (got.red_out !== want.red_out) report("red_out", got.red_out, want.red_out);
      if (got.green_out !== want.green_out) report("green_out", got.green_out, want.green_out);
      if (got.blue_out !== want.blue_out) report("blue_out", got.blue_out, want.blue_out);
      if (got.out_column !== want.out_column)
        report("out_column", got.out_column, want.out_column);
      if (got.out_row !== want.out_row) report("out_row", got.out_row, want.out_row);
      if (got.last_in_run !== want.last_in_run)
        report("last_in_run", got.last_in_run, want.last_in_run);
      if (got.frame_done !== want.frame_done)
        report("frame_done", got.frame_done, want.frame_done);
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  sgb_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  sgb_out_t    out_data_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [16:0] cfg_data_i = '0;

  blur_scoreboard sb = new();
  bit  calm = 1'b0;          // no idling on either side while set
  int  beats_sent = 0;
  int  frames_run = 0;

  always #1 clk_i = ~clk_i;

  separable_gaussian_blur_rgb_core u_top (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // receiver: random stall, changed on the falling edge
  always @(negedge clk_i) out_stall_i <= calm ? 1'b0 : ($urandom_range(0, 99) < 23);

  // result beats are checked at the rising edge they are taken
  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i) sb.check(out_data_o);

  // one input beat, with random gaps before it; returns once the core takes it
  task send_beat(sgb_in_t d);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < 23) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = d;
    do @(posedge clk_i); while (in_stall_o);
    sb.note(d);
    beats_sent++;
  endtask

  task write_reg(cfg_idx_e idx, logic [16:0] val);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    cfg_we_i = 1'b1; cfg_idx_i = idx; cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_reg(idx, val);
  endtask

  // all owed results in, then an idle margin with the input low
  task wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function logic [7:0] chan(bit extreme);
    if (extreme || $urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 8'hff : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  function logic [16:0] pick_coef();
    case ($urandom_range(0, 5))
      0:       return 17'd0;
      1:       return 17'h10000;
      2:       return 17'($urandom_range(0, 65536));
      default: return 17'($urandom_range(0, 16384));
    endcase
  endfunction

  // program every register, push a frame with stray drains in it, then some number of drain beats
  task run_frame(logic [10:0] w, logic [12:0] h, logic [2:0] r, logic [16:0] c [NCOEF],
                 bit extreme, int drain_mode, output int n_items);
    sgb_in_t d;
    int      npix;
    int      ndrain;
    write_reg(CFG_IMAGE_WIDTH, 17'(w));
    write_reg(CFG_IMAGE_HEIGHT, 17'(h));
    write_reg(CFG_BLUR_RADIUS, 17'(r));
    for (int i = 0; i < NCOEF; i++) write_reg(cfg_idx_e'(int'(CFG_COEF_CENTER) + i), c[i]);
    npix = sb.eff_w() * sb.eff_h();
    n_items = 0;
    for (int p = 0; p < npix; p++) begin
      // stray drain inside the frame: nothing pending, so no result
      if (p > 0 && $urandom_range(0, 99) < 6) begin
        d = '0; d.command = CMD_DRAIN;
        d.red_in = chan(0); d.green_in = chan(0); d.blue_in = chan(0);
        send_beat(d);
        n_items++;
      end
      d.command = CMD_PIXEL;
      d.red_in = chan(extreme); d.green_in = chan(extreme); d.blue_in = chan(extreme);
      send_beat(d);
      n_items++;
    end
    // full flush, flush plus surplus, or a short flush abandoned by the next frame
    ndrain = sb.drain_left;
    if (drain_mode == 1) ndrain += 2;
    else if (drain_mode == 2) ndrain = $urandom_range(0, ndrain);
    for (int i = 0; i < ndrain; i++) begin
      d = '0; d.command = CMD_DRAIN;
      d.red_in = chan(0); d.green_in = chan(0); d.blue_in = chan(0);
      send_beat(d);
      n_items++;
    end
    wait_idle();
    frames_run++;
  endtask

  initial begin
    logic [16:0] c [NCOEF];
    int          n, random_items, k;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: zero sizes clamp to one pixel, drain with nothing pending
    c[0] = 17'h10000; for (int i = 1; i < NCOEF; i++) c[i] = 17'd0;
    run_frame(11'd0, 13'd0, 3'd0, c, 1'b1, 1, n);
    // radius above the maximum saturates, full weights drive the channels into saturation
    for (int i = 0; i < NCOEF; i++) c[i] = 17'h10000;
    run_frame(11'd3, 13'd2, 3'd7, c, 1'b1, 0, n);
    // one nonzero weight only, mirrored borders at radius larger than the frame
    for (int i = 0; i < NCOEF; i++) c[i] = (i == 2) ? 17'd30000 : 17'd0;
    run_frame(11'd2, 13'd3, 3'd4, c, 1'b1, 1, n);

    // random small frames, two of them with no idling on either side
    random_items = 0; k = 0;
    while (random_items < 60 || k < 3) begin
      logic [10:0] w;
      logic [12:0] h;
      calm = (k >= 1 && k < 3);
      for (int i = 0; i < NCOEF; i++) c[i] = pick_coef();
      w = 11'($urandom_range(1, 12)); h = 13'($urandom_range(1, 7));
      run_frame(w, h, 3'($urandom_range(0, 7)), c, 1'b0, $urandom_range(0, 3) == 3 ? 2
                : $urandom_range(0, 1), n);
      random_items += n;
      k++;
    end
    calm = 1'b0;

    wait_idle();
    if (sb.owed_q.size() != 0) sb.report("results never delivered", 0, sb.owed_q.size());
    $display("covered %0d frames, %0d input beats, %0d result beats checked",
             frames_run, beats_sent, sb.results);
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: separable_gaussian_blur_rgb_core.f
src/sgb_pkg.sv
src/sgb_ram.sv
src/sgb_tap_lane.sv
src/sgb_merge.sv
src/separable_gaussian_blur_rgb_core.sv
tb/sv/separable_gaussian_blur_rgb_core_test.sv
